// ===== rtl/core/translucency_nearest_palette_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the translucency nearest palette unit
// Shared concurrent check forms, each clocked on a rising edge and disabled
// while the asynchronous active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef TRANSLUCENCY_NEAREST_PALETTE_UNIT_DEFINES_SVH
`define TRANSLUCENCY_NEAREST_PALETTE_UNIT_DEFINES_SVH

// Same-cycle implication: the consequent is checked at the antecedent's edge.
`define TNP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tnp: same-cycle implication check failed");

// Next-cycle implication: the consequent is checked after the antecedent's edge.
`define TNP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tnp: next-cycle implication check failed");

`endif

// ===== rtl/core/tnp_pkg.sv =====
// ----------------------------------------------------------------------------
// tnp_pkg
// Constants, types and helpers shared by the nearest palette blend unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tnp_pkg;

	// Palette size and blend weight precision.
	localparam int PALETTE_ENTRIES      = 256;
	localparam int WEIGHT_FRACTION_BITS = 12;

	// Field widths.
	localparam int CH_W        = 8;
	localparam int IDX_FIELD_W = 8;
	localparam int PCT_W       = 7;
	localparam int IDX_W       = $clog2(PALETTE_ENTRIES);

	// Datapath widths.
	localparam int W_W    = WEIGHT_FRACTION_BITS + 1;          // weight, up to 2^WFB
	localparam int M_W    = CH_W + WEIGHT_FRACTION_BITS;       // blended channel
	localparam int SQ_W   = 2 * CH_W + 2;                      // sum of three squares
	localparam int EN_W   = SQ_W + WEIGHT_FRACTION_BITS - 1;   // stored energy
	localparam int PROD_W = CH_W + M_W;                        // channel times blend
	localparam int ERR_W  = EN_W + 3;                          // signed error
	localparam int BL_W   = CH_W + 1 + W_W + 1;                // blend arithmetic

	// Blend percent register.
	localparam logic [PCT_W-1:0] PCT_RESET = PCT_W'(66);
	localparam logic [PCT_W-1:0] PCT_FULL  = PCT_W'(100);

	// Front weight is floor(pct * 2^WFB / 100), done as a multiply by a
	// rounded-up reciprocal. The error stays below pct / 2^BLEND_SH, far under
	// the 1/100 gap between distinct quotient fractions, so the floor is exact.
	localparam int BLEND_SH = 16;
	localparam int K_W      = WEIGHT_FRACTION_BITS + 10;
	localparam logic [K_W-1:0] BLEND_K =
		K_W'((64'd1 << (WEIGHT_FRACTION_BITS + BLEND_SH)) / 64'd100 + 64'd1);

	// Operation codes of the request.
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} color_t;

	typedef enum logic [1:0] {
		CH_RED,
		CH_GREEN,
		CH_BLUE
	} chan_t;

	typedef enum logic [1:0] {
		RD_FRONT,
		RD_BACK,
		RD_SCAN
	} rd_src_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LD_SQ,
		ST_LD_WR,
		ST_Q_RDF,
		ST_Q_RDB,
		ST_Q_BLEND,
		ST_SCAN,
		ST_DRAIN
	} tnp_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             capture;
		logic             ld_square;
		logic             ld_write;
		logic             rd_en;
		rd_src_t          rd_src;
		logic [IDX_W-1:0] scan_addr;
		logic             latch_front;
		logic             blend_en;
		chan_t            chan;
		logic             scan_start;
		logic             out_load;
	} tnp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic pipe_busy;
	} tnp_status_t;

	// Selects one channel of a color.
	function automatic logic [CH_W-1:0] chan_pick(color_t c, chan_t ch);
		logic [CH_W-1:0] v;
		case (ch)
			CH_RED:   v = c.red;
			CH_GREEN: v = c.green;
			CH_BLUE:  v = c.blue;
			default:  v = '0;
		endcase
		return v;
	endfunction

	// Steps through the three channels in order.
	function automatic chan_t chan_next(chan_t ch);
		chan_t n;
		case (ch)
			CH_RED:   n = CH_GREEN;
			CH_GREEN: n = CH_BLUE;
			default:  n = CH_RED;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tnp_ctrl.sv =====
// ----------------------------------------------------------------------------
// tnp_ctrl
// Controller that sequences palette loads, the blend of a query pair, the
// palette scan and the hand-off of the chosen index to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tnp_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire                 operation,
	output logic                out_valid,
	input  wire                 out_ready,
	input  tnp_pkg::tnp_status_t status,
	output tnp_pkg::tnp_cmd_t   cmd
);
	import tnp_pkg::*;

	localparam logic [IDX_W-1:0] SCAN_FIRST = IDX_W'(PALETTE_ENTRIES - 1);

	tnp_state_t       state_q, state_d;
	chan_t            chan_q, chan_d;
	logic [IDX_W-1:0] cnt_q, cnt_d;
	logic             out_valid_q, out_valid_d;

	// State and sequencing registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			chan_q      <= CH_RED;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			chan_q      <= chan_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d     = state_q;
		chan_d      = chan_q;
		cnt_d       = cnt_q;
		out_valid_d = out_valid_q && !out_ready;
		in_ready    = 1'b0;
		cmd         = '0;
		cmd.rd_src  = RD_SCAN;
		cmd.chan    = chan_q;
		cmd.scan_addr = cnt_q;

		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					chan_d      = CH_RED;
					state_d     = (operation == OP_QUERY) ? ST_Q_RDF : ST_LD_SQ;
				end
			end
			ST_LD_SQ: begin
				cmd.ld_square = 1'b1;
				chan_d        = chan_next(chan_q);
				if (chan_q == CH_BLUE) begin
					state_d = ST_LD_WR;
				end
			end
			ST_LD_WR: begin
				cmd.ld_write = 1'b1;
				state_d      = ST_IDLE;
			end
			ST_Q_RDF: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_src = RD_FRONT;
				state_d    = ST_Q_RDB;
			end
			ST_Q_RDB: begin
				cmd.rd_en       = 1'b1;
				cmd.rd_src      = RD_BACK;
				cmd.latch_front = 1'b1;
				chan_d          = CH_RED;
				state_d         = ST_Q_BLEND;
			end
			ST_Q_BLEND: begin
				cmd.blend_en = 1'b1;
				chan_d       = chan_next(chan_q);
				if (chan_q == CH_BLUE) begin
					cmd.scan_start = 1'b1;
					cnt_d          = SCAN_FIRST;
					state_d        = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_src = RD_SCAN;
				if (cnt_q == '0) begin
					state_d = ST_DRAIN;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_DRAIN: begin
				// Wait for the compare pipeline to empty and the output to be free.
				if (!status.pipe_busy && (!out_valid_q || out_ready)) begin
					cmd.out_load = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/core/tnp_datapath.sv =====
// ----------------------------------------------------------------------------
// tnp_datapath
// Palette and energy memories, blend arithmetic, the four-stage error
// pipeline of the scan, the running minimum and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tnp_datapath (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  tnp_pkg::tnp_cmd_t                    cmd,
	output tnp_pkg::tnp_status_t                 status,
	input  wire                                  cfg_wr_en,
	input  wire  [tnp_pkg::PCT_W-1:0]            cfg_wr_data,
	input  wire  [tnp_pkg::IDX_FIELD_W-1:0]      entry_index,
	input  wire  [tnp_pkg::CH_W-1:0]             entry_red,
	input  wire  [tnp_pkg::CH_W-1:0]             entry_green,
	input  wire  [tnp_pkg::CH_W-1:0]             entry_blue,
	input  wire  [tnp_pkg::IDX_FIELD_W-1:0]      front_index,
	input  wire  [tnp_pkg::IDX_FIELD_W-1:0]      back_index,
	output logic [tnp_pkg::IDX_FIELD_W-1:0]      blended_index
);
	import tnp_pkg::*;

	localparam logic [IDX_FIELD_W:0] ENTRY_LIMIT = (IDX_FIELD_W + 1)'(PALETTE_ENTRIES);
	localparam int WPROD_W = PCT_W + K_W;

	// Memories.
	color_t          pal_mem [PALETTE_ENTRIES];
	logic [EN_W-1:0] en_mem  [PALETTE_ENTRIES];

	// Configuration and weight.
	logic [PCT_W-1:0]   blend_percent_q;
	logic [PCT_W-1:0]   pct_sat;
	logic [WPROD_W-1:0] wprod;
	logic [W_W-1:0]     w1_q;

	// Captured request fields.
	logic [IDX_FIELD_W-1:0] ld_idx_q;
	color_t                 ld_color_q;
	logic [IDX_FIELD_W-1:0] front_idx_q;
	logic [IDX_FIELD_W-1:0] back_idx_q;

	// Load energy.
	logic [CH_W-1:0]   ld_ch;
	logic [2*CH_W-1:0] ld_sq;
	logic [SQ_W-1:0]   en_acc_q;
	logic              ld_in_range;

	// Memory read port.
	logic [IDX_FIELD_W-1:0] rd_addr;
	logic                   rd_oor;
	color_t                 rd_color_s1;
	logic [EN_W-1:0]        rd_energy_s1;
	logic                   rd_oor_s1;
	color_t                 rd_view;

	// Blend.
	color_t                 front_col_q;
	logic [CH_W-1:0]        bl_f;
	logic [CH_W-1:0]        bl_b;
	logic signed [CH_W:0]   bl_diff;
	logic signed [BL_W-1:0] bl_prod;
	logic signed [BL_W-1:0] bl_sum;
	logic [M_W-1:0]         m_red_q;
	logic [M_W-1:0]         m_green_q;
	logic [M_W-1:0]         m_blue_q;

	// Scan pipeline.
	logic                    v_s1, v_s2, v_s3, v_s4;
	logic [IDX_W-1:0]        idx_s1, idx_s2, idx_s3, idx_s4;
	logic [CH_W-1:0]         green_s2, blue_s2, blue_s3;
	logic signed [ERR_W-1:0] acc_s2, acc_s3, err_s4;
	logic [PROD_W-1:0]       prod_r, prod_g, prod_b;

	// Running minimum and result.
	logic                    best_v_q;
	logic signed [ERR_W-1:0] best_q;
	logic [IDX_W-1:0]        chosen_q;
	logic [IDX_FIELD_W-1:0]  blended_q;

	// Blend percent register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_percent_q <= PCT_RESET;
		end else if (cfg_wr_en) begin
			blend_percent_q <= cfg_wr_data;
		end
	end

	// Front weight, floor(pct * 2^WFB / 100) by reciprocal multiply.
	assign pct_sat = (blend_percent_q > PCT_FULL) ? PCT_FULL : blend_percent_q;
	assign wprod   = WPROD_W'(pct_sat) * WPROD_W'(BLEND_K);

	always_ff @(posedge clk) begin
		w1_q <= wprod[BLEND_SH +: W_W];
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ld_idx_q         <= entry_index;
			ld_color_q.red   <= entry_red;
			ld_color_q.green <= entry_green;
			ld_color_q.blue  <= entry_blue;
			front_idx_q      <= front_index;
			back_idx_q       <= back_index;
		end
	end

	// Energy of a loaded entry, one channel square per cycle.
	assign ld_ch = chan_pick(ld_color_q, cmd.chan);
	assign ld_sq = ld_ch * ld_ch;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			en_acc_q <= '0;
		end else if (cmd.ld_square) begin
			en_acc_q <= en_acc_q + SQ_W'(ld_sq);
		end
	end

	// Palette write; loads beyond the palette are dropped.
	assign ld_in_range = ({1'b0, ld_idx_q} < ENTRY_LIMIT);

	always_ff @(posedge clk) begin
		if (cmd.ld_write && ld_in_range) begin
			pal_mem[ld_idx_q[IDX_W-1:0]] <= ld_color_q;
			en_mem[ld_idx_q[IDX_W-1:0]]  <= {en_acc_q, {(WEIGHT_FRACTION_BITS-1){1'b0}}};
		end
	end

	// Read address selection.
	always_comb begin
		case (cmd.rd_src)
			RD_FRONT: rd_addr = front_idx_q;
			RD_BACK:  rd_addr = back_idx_q;
			default:  rd_addr = IDX_FIELD_W'(cmd.scan_addr);
		endcase
	end

	assign rd_oor = ({1'b0, rd_addr} >= ENTRY_LIMIT);

	// Registered memory read.
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_color_s1  <= pal_mem[rd_addr[IDX_W-1:0]];
			rd_energy_s1 <= en_mem[rd_addr[IDX_W-1:0]];
			rd_oor_s1    <= rd_oor;
			idx_s1       <= cmd.scan_addr;
		end
	end

	// An index beyond the palette reads as black.
	assign rd_view = rd_oor_s1 ? '0 : rd_color_s1;

	// Blend of one channel: back * 2^WFB + (front - back) * w1.
	always_ff @(posedge clk) begin
		if (cmd.latch_front) begin
			front_col_q <= rd_view;
		end
	end

	assign bl_f    = chan_pick(front_col_q, cmd.chan);
	assign bl_b    = chan_pick(rd_view, cmd.chan);
	assign bl_diff = $signed({1'b0, bl_f}) - $signed({1'b0, bl_b});
	assign bl_prod = BL_W'(bl_diff) * BL_W'($signed({1'b0, w1_q}));
	assign bl_sum  = bl_prod
		+ $signed({{(BL_W-CH_W-WEIGHT_FRACTION_BITS){1'b0}}, bl_b,
			{WEIGHT_FRACTION_BITS{1'b0}}});

	always_ff @(posedge clk) begin
		if (cmd.blend_en) begin
			case (cmd.chan)
				CH_RED:   m_red_q   <= bl_sum[M_W-1:0];
				CH_GREEN: m_green_q <= bl_sum[M_W-1:0];
				default:  m_blue_q  <= bl_sum[M_W-1:0];
			endcase
		end
	end

	// Scan pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en && (cmd.rd_src == RD_SCAN);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Error = energy - r*R - g*G - b*B, one product per stage.
	assign prod_r = rd_view.red * m_red_q;
	assign prod_g = green_s2 * m_green_q;
	assign prod_b = blue_s3 * m_blue_q;

	always_ff @(posedge clk) begin
		acc_s2   <= $signed(ERR_W'(rd_energy_s1)) - $signed(ERR_W'(prod_r));
		green_s2 <= rd_view.green;
		blue_s2  <= rd_view.blue;
		idx_s2   <= idx_s1;
		acc_s3   <= acc_s2 - $signed(ERR_W'(prod_g));
		blue_s3  <= blue_s2;
		idx_s3   <= idx_s2;
		err_s4   <= acc_s3 - $signed(ERR_W'(prod_b));
		idx_s4   <= idx_s3;
	end

	// Running minimum; only a strictly smaller error replaces the best, so the
	// highest index wins a tie since the scan runs downward.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_v_q <= 1'b0;
		end else if (cmd.scan_start) begin
			best_v_q <= 1'b0;
		end else if (v_s4) begin
			best_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s4 && (!best_v_q || (err_s4 < best_q))) begin
			best_q   <= err_s4;
			chosen_q <= idx_s4;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			blended_q <= IDX_FIELD_W'(chosen_q);
		end
	end

	assign blended_index    = blended_q;
	assign status.pipe_busy = v_s1 || v_s2 || v_s3 || v_s4;

endmodule

`default_nettype wire

// ===== rtl/core/translucency_nearest_palette_unit.sv =====
// ----------------------------------------------------------------------------
// translucency_nearest_palette_unit: nearest palette entry to a blend of two.
// A query result is loaded into the output register once the scan of every palette entry has drained.
// The block takes no new request until a load or query is finished; a stalled result delays the next scan.
// Reset: arst_n clears control state and sets blend percent to 66; palette is undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module translucency_nearest_palette_unit (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire                                  operation,
	input  wire  [tnp_pkg::IDX_FIELD_W-1:0]      entry_index,
	input  wire  [tnp_pkg::CH_W-1:0]             entry_red,
	input  wire  [tnp_pkg::CH_W-1:0]             entry_green,
	input  wire  [tnp_pkg::CH_W-1:0]             entry_blue,
	input  wire  [tnp_pkg::IDX_FIELD_W-1:0]      front_index,
	input  wire  [tnp_pkg::IDX_FIELD_W-1:0]      back_index,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic [tnp_pkg::IDX_FIELD_W-1:0]      blended_index,
	input  wire                                  cfg_wr_en,
	input  wire  [tnp_pkg::PCT_W-1:0]            cfg_wr_data
);
	import tnp_pkg::*;

	tnp_cmd_t    cmd;
	tnp_status_t status;

	// Sequencer.
	tnp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Memories, arithmetic and result register.
	tnp_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.entry_index   (entry_index),
		.entry_red     (entry_red),
		.entry_green   (entry_green),
		.entry_blue    (entry_blue),
		.front_index   (front_index),
		.back_index    (back_index),
		.blended_index (blended_index)
	);

endmodule

`default_nettype wire

// ===== rtl/core/tnp_checker.sv =====
// ----------------------------------------------------------------------------
// tnp_checker
// Port-level checks of the nearest palette unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "translucency_nearest_palette_unit_defines.svh"

module tnp_checker (
	input wire                             clk,
	input wire                             arst_n,
	input wire                             in_valid,
	input wire                             in_ready,
	input wire                             operation,
	input wire                             out_valid,
	input wire                             out_ready,
	input wire [tnp_pkg::IDX_FIELD_W-1:0]  blended_index
);
	import tnp_pkg::*;

	logic query_acc;
	logic load_acc;

	assign query_acc = in_valid && in_ready && (operation == OP_QUERY);
	assign load_acc  = in_valid && in_ready && (operation == OP_LOAD);

	// A query occupies the block, so no request is taken right after it.
	`TNP_ASSERT_NEXT(a_query_blocks_input, clk, arst_n, query_acc, !in_ready)

	// The block still holds off new requests while it scans after a query.
	`TNP_ASSERT_IMPLY(a_query_still_busy, clk, arst_n, query_acc, ##8 !in_ready)

	// A load never produces a result.
	`TNP_ASSERT_NEXT(a_load_no_result, clk, arst_n, load_acc, !$rose(out_valid))

	// A stalled result holds its index.
	`TNP_ASSERT_NEXT(a_result_holds, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(blended_index))

endmodule

bind translucency_nearest_palette_unit tnp_checker u_tnp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.operation     (operation),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.blended_index (blended_index)
);

`default_nettype wire

// ===== tb/sv/blend_lookup_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Blend lookup checker
// Watches the request, result and register ports of the nearest palette blend
// unit. It keeps its own copy of the palette, the stored energies and the
// blend percent, predicts the index that each query should return, and
// compares the returned indexes in order.
// ----------------------------------------------------------------------------
module blend_lookup_checker (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  in_valid,
	input  wire                                  in_ready,
	input  wire                                  operation,
	input  wire  [tnp_pkg::IDX_FIELD_W-1:0]      entry_index,
	input  wire  [tnp_pkg::CH_W-1:0]             entry_red,
	input  wire  [tnp_pkg::CH_W-1:0]             entry_green,
	input  wire  [tnp_pkg::CH_W-1:0]             entry_blue,
	input  wire  [tnp_pkg::IDX_FIELD_W-1:0]      front_index,
	input  wire  [tnp_pkg::IDX_FIELD_W-1:0]      back_index,
	input  wire                                  out_valid,
	input  wire                                  out_ready,
	input  wire  [tnp_pkg::IDX_FIELD_W-1:0]      blended_index,
	input  wire                                  cfg_wr_en,
	input  wire  [tnp_pkg::PCT_W-1:0]            cfg_wr_data,
	output int                                   mismatches,
	output int                                   pending
);

	localparam int MAX_REPORTS = 10;

	tnp_pkg::color_t                 palette_copy [tnp_pkg::PALETTE_ENTRIES];
	logic [tnp_pkg::EN_W-1:0]        energy_copy  [tnp_pkg::PALETTE_ENTRIES];
	logic [tnp_pkg::PCT_W-1:0]       blend_pct;
	logic [tnp_pkg::IDX_FIELD_W-1:0] expected_blend_idx [$];
	logic [tnp_pkg::IDX_FIELD_W-1:0] oldest_idx;
	int                              queries_taken;
	int                              results_seen;
	int                              fail_count = 0;

	assign pending    = queries_taken - results_seen;
	assign mismatches = fail_count;

	// Blend the two colors with the current weights, then scan the palette from
	// the top entry down; only a strictly smaller error moves the choice, so
	// ties stay with the higher index.
	function automatic logic [tnp_pkg::IDX_FIELD_W-1:0] nearest_blend_entry(
		tnp_pkg::color_t front, tnp_pkg::color_t back);
		logic [tnp_pkg::PCT_W-1:0]       pct;
		logic [tnp_pkg::IDX_FIELD_W-1:0] pick;
		longint                          w_front;
		longint                          w_back;
		longint                          mix_r;
		longint                          mix_g;
		longint                          mix_b;
		longint                          err;
		longint                          best;
		int                              c;
		pct     = (blend_pct > tnp_pkg::PCT_FULL) ? tnp_pkg::PCT_FULL : blend_pct;
		w_front = (longint'(pct) << tnp_pkg::WEIGHT_FRACTION_BITS)
			/ longint'(tnp_pkg::PCT_FULL);
		w_back  = (longint'(1) << tnp_pkg::WEIGHT_FRACTION_BITS) - w_front;
		mix_r   = longint'(front.red) * w_front + longint'(back.red) * w_back;
		mix_g   = longint'(front.green) * w_front + longint'(back.green) * w_back;
		mix_b   = longint'(front.blue) * w_front + longint'(back.blue) * w_back;
		best    = 64'sh7FFF_FFFF_FFFF_FFFF;
		pick    = '0;
		for (c = tnp_pkg::PALETTE_ENTRIES - 1; c >= 0; c--) begin
			err = longint'(energy_copy[c])
				- longint'(palette_copy[c].red) * mix_r
				- longint'(palette_copy[c].green) * mix_g
				- longint'(palette_copy[c].blue) * mix_b;
			if (err < best) begin
				best = err;
				pick = tnp_pkg::IDX_FIELD_W'(c);
			end
		end
		return pick;
	endfunction

	// Track the register, the palette and the order of outstanding queries.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_pct     <= tnp_pkg::PCT_RESET;
			queries_taken <= 0;
			results_seen  <= 0;
			expected_blend_idx.delete();
		end else begin
			if (cfg_wr_en) begin
				blend_pct <= cfg_wr_data;
			end

			// Returned results are matched against the oldest open query.
			if (out_valid && out_ready) begin
				results_seen <= results_seen + 1;
				if (expected_blend_idx.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS) begin
						$display("[%0t] unexpected blended_index %0d with no query open",
							$realtime, blended_index);
					end
				end else begin
					oldest_idx = expected_blend_idx.pop_front();
					if (blended_index !== oldest_idx) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS) begin
							$display("[%0t] blended_index mismatch: expected %0d, got %0d",
								$realtime, oldest_idx, blended_index);
						end
					end
				end
			end

			// A load updates the palette copy; a query queues its prediction.
			if (in_valid && in_ready) begin
				if (operation == tnp_pkg::OP_LOAD) begin
					palette_copy[entry_index] = {entry_red, entry_green, entry_blue};
					energy_copy[entry_index]  = tnp_pkg::EN_W'(
						(longint'(entry_red) * longint'(entry_red)
						+ longint'(entry_green) * longint'(entry_green)
						+ longint'(entry_blue) * longint'(entry_blue))
						<< (tnp_pkg::WEIGHT_FRACTION_BITS - 1));
				end else begin
					expected_blend_idx.push_back(nearest_blend_entry(
						palette_copy[front_index], palette_copy[back_index]));
					queries_taken <= queries_taken + 1;
				end
			end
		end
	end

endmodule

// ===== tb/sv/translucency_nearest_palette_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Translucency nearest palette unit testbench
// Fills the whole palette, runs directed blend queries around black, white,
// primaries, reloaded entries and equal-error ties, then random mixes of
// loads and queries under several blend percents, including saturation.
// Both channels idle at random; a separate checker predicts every result.
// ----------------------------------------------------------------------------
module translucency_nearest_palette_unit_tb;

	localparam int RESET_CYCLES  = 11;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int LOAD_SETTLE   = 10;
	localparam int QUERY_LATENCY = tnp_pkg::PALETTE_ENTRIES + 10;
	localparam int PHASE_COUNT   = 6;
	localparam int PHASE_ITEMS   = 40;

	logic                             clk           = 1'b0;
	logic                             arst_n        = 1'b0;
	logic                             in_valid      = 1'b0;
	logic                             in_ready;
	logic                             operation     = tnp_pkg::OP_LOAD;
	logic [tnp_pkg::IDX_FIELD_W-1:0]  entry_index   = '0;
	logic [tnp_pkg::CH_W-1:0]         entry_red     = '0;
	logic [tnp_pkg::CH_W-1:0]         entry_green   = '0;
	logic [tnp_pkg::CH_W-1:0]         entry_blue    = '0;
	logic [tnp_pkg::IDX_FIELD_W-1:0]  front_index   = '0;
	logic [tnp_pkg::IDX_FIELD_W-1:0]  back_index    = '0;
	logic                             out_valid;
	logic                             out_ready     = 1'b0;
	logic [tnp_pkg::IDX_FIELD_W-1:0]  blended_index;
	logic                             cfg_wr_en     = 1'b0;
	logic [tnp_pkg::PCT_W-1:0]        cfg_wr_data   = '0;
	int                               send_idle_pct = 0;
	int                               recv_idle_pct = 0;
	int                               cycle_count   = 0;
	int                               mismatches;
	int                               pending;

	translucency_nearest_palette_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.entry_index   (entry_index),
		.entry_red     (entry_red),
		.entry_green   (entry_green),
		.entry_blue    (entry_blue),
		.front_index   (front_index),
		.back_index    (back_index),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.blended_index (blended_index),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	blend_lookup_checker blend_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.entry_index   (entry_index),
		.entry_red     (entry_red),
		.entry_green   (entry_green),
		.entry_blue    (entry_blue),
		.front_index   (front_index),
		.back_index    (back_index),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.blended_index (blended_index),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.mismatches    (mismatches),
		.pending       (pending)
	);

	// Free-running clock, 2 ns period.
	always #1 clk = ~clk;

	// The result side stalls at random with the current idle percentage.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Hard stop if the run hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Present one request, with random idle cycles ahead of it, and hold it
	// until the edge at which it is accepted.
	task automatic push_request(input logic op,
		input logic [tnp_pkg::IDX_FIELD_W-1:0] idx,
		input tnp_pkg::color_t color,
		input logic [tnp_pkg::IDX_FIELD_W-1:0] front,
		input logic [tnp_pkg::IDX_FIELD_W-1:0] back);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		operation   <= op;
		entry_index <= idx;
		entry_red   <= color.red;
		entry_green <= color.green;
		entry_blue  <= color.blue;
		front_index <= front;
		back_index  <= back;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic load_entry(input int idx, input tnp_pkg::color_t color);
		push_request(tnp_pkg::OP_LOAD, tnp_pkg::IDX_FIELD_W'(idx), color,
			tnp_pkg::IDX_FIELD_W'($urandom_range(255)),
			tnp_pkg::IDX_FIELD_W'($urandom_range(255)));
	endtask

	task automatic query_pair(input int front, input int back);
		push_request(tnp_pkg::OP_QUERY, tnp_pkg::IDX_FIELD_W'($urandom_range(255)),
			{8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255))},
			tnp_pkg::IDX_FIELD_W'(front), tnp_pkg::IDX_FIELD_W'(back));
	endtask

	// Channel values lean toward the extremes a quarter of the time.
	function automatic logic [tnp_pkg::CH_W-1:0] pick_channel();
		int roll;
		roll = $urandom_range(7);
		if (roll == 0)
			return '0;
		else if (roll == 1)
			return '1;
		return tnp_pkg::CH_W'($urandom_range(255));
	endfunction

	// Stop requesting, wait for every query result, then let a trailing load
	// finish before touching the register.
	task automatic drain_requests();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (LOAD_SETTLE) @(posedge clk);
	endtask

	task automatic write_blend_pct(input logic [tnp_pkg::PCT_W-1:0] pct);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= pct;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	// Stimulus and verdict.
	initial begin
		int              i;
		int              phase;
		tnp_pkg::color_t color;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n        <= 1'b1;
		send_idle_pct <= 29;
		recv_idle_pct <= 59;
		@(posedge clk);

		// Every entry is loaded before the first query, since a scan reads all.
		// Entries 128 and 254 share a gray so that a gray blend ties.
		for (i = 0; i < tnp_pkg::PALETTE_ENTRIES; i++) begin
			case (i)
				0:        color = {8'd0, 8'd0, 8'd0};
				1:        color = {8'd255, 8'd0, 8'd0};
				2:        color = {8'd0, 8'd255, 8'd0};
				3:        color = {8'd0, 8'd0, 8'd255};
				128, 254: color = {8'd128, 8'd128, 8'd128};
				255:      color = {8'd255, 8'd255, 8'd255};
				default:  color = {pick_channel(), pick_channel(), pick_channel()};
			endcase
			load_entry(i, color);
		end

		// Directed queries at the reset blend percent.
		query_pair(0, 255);
		query_pair(255, 0);
		query_pair(1, 2);
		query_pair(2, 3);
		query_pair(3, 1);
		query_pair(128, 128);
		query_pair(255, 255);
		query_pair(0, 0);
		load_entry(5, {8'd255, 8'd255, 8'd0});
		query_pair(5, 5);
		query_pair(5, 0);
		drain_requests();

		// Random phases, each under its own blend percent; each pair of phases shares an idle pattern.
		for (phase = 0; phase < PHASE_COUNT; phase++) begin
			case (phase / 2)
				0: begin
					send_idle_pct <= 29;
					recv_idle_pct <= 59;
				end
				1: begin
					send_idle_pct <= 59;
					recv_idle_pct <= 29;
				end
				default: begin
					send_idle_pct <= 0;
					recv_idle_pct <= 0;
				end
			endcase
			case (phase)
				0:       write_blend_pct(7'd0);
				1:       write_blend_pct(tnp_pkg::PCT_FULL);
				2:       write_blend_pct(7'd127);
				3:       write_blend_pct(7'd50);
				4:       write_blend_pct(7'($urandom_range(126, 101)));
				default: write_blend_pct(7'($urandom_range(100)));
			endcase
			for (i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(99) < 60) begin
					query_pair($urandom_range(255), $urandom_range(255));
				end else begin
					load_entry($urandom_range(255),
						{pick_channel(), pick_channel(), pick_channel()});
				end
			end
			drain_requests();
		end

		// Give any stray result time to show up before the verdict.
		repeat (QUERY_LATENCY) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
